// ----- sv/sada_pkg.sv -----
// shared types and constants for the sensor advertisement decoder
`timescale 1ns / 1ps
package sada_pkg;

  localparam int DEF_MIN_FRAME_BYTES = 24;
  localparam int DEF_COUNT_BITS      = 16;

  localparam int MAC_W       = 48;
  localparam int FIELDS_W    = 48;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 120;
  localparam int POS_W       = 6;

  localparam logic [POS_W-1:0] POS_MAX        = 6'd63;
  localparam logic [POS_W-1:0] HDR_BYTES      = 6'd3;
  localparam logic [POS_W-1:0] FIELD_END      = 6'd9;
  localparam logic [7:0]       HDR_BYTE0      = 8'h99;
  localparam logic [7:0]       HDR_BYTE1      = 8'h04;
  localparam logic [7:0]       HDR_BYTE2      = 8'h05;
  localparam logic [16:0]      PRESSURE_OFFSET = 17'd50000;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    FS_ACCEPTED   = 2'd0,
    FS_TOO_SHORT  = 2'd1,
    FS_BAD_HEADER = 2'd2,
    FS_BAD_ADDR   = 2'd3
  } frame_status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ACCUM,
    BK_LOAD,
    BK_DIV,
    BK_OUT
  } back_state_t;

  // one queued event: a clear command or a judged frame
  typedef struct packed {
    logic                is_clear;
    frame_status_t       status;
    logic [FIELDS_W-1:0] fields;
  } sada_evt_t;

  typedef struct packed {
    logic full;
    logic empty;
  } sada_qstat_t;

  function automatic logic [7:0] header_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = HDR_BYTE0;
      2'd1:    b = HDR_BYTE1;
      default: b = HDR_BYTE2;
    endcase
    return b;
  endfunction

endpackage

// ----- sv/sensor_advert_decode_average.sv -----
// top level of the sensor advertisement decoder with running averages
`timescale 1ns / 1ps
// Takes manufacturer-data bytes one word per cycle and judges each frame at
// its tlast word: length, the 99 04 05 header and the sender address against
// allowed_mac. An accepted frame updates the latest temperature, humidity
// and pressure and the running sums; every frame end gives one result word
// with status, latest values, truncated averages and the sample count. A
// word with in_tuser set clears the averages and gives no result. Input
// words are taken every cycle while the two-entry event queue has room; each
// frame end occupies the back end while it is taken from the queue,
// accumulated, loaded, run through 17 + COUNT_BITS restoring divide steps
// shared by three lanes and put in the output register, plus any wait on
// out_tready. A clear word is taken from the queue without any divide.
module sensor_advert_decode_average import sada_pkg::*; #(
  parameter int MIN_FRAME_BYTES = DEF_MIN_FRAME_BYTES,
  parameter int COUNT_BITS      = DEF_COUNT_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [MAC_W-1:0]       cfg_wdata,     // allowed_mac
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,      // data_byte, sender_mac
  input  logic                   in_tuser,      // command
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // frame_status, latest_temperature, latest_humidity, latest_pressure,
  // average_valid, average_temperature, average_humidity, average_pressure,
  // sample_count, zero fill
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  sada_evt_t   q_wdata;
  sada_evt_t   q_head;
  sada_qstat_t q_stat;
  logic        q_push;
  logic        q_pop;

  sada_front #(
    .MIN_FRAME_BYTES(MIN_FRAME_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  sada_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_head),
    .stat  (q_stat)
  );

  sada_back #(
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_head     (q_head),
    .q_stat     (q_stat),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("event pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("event popped from an empty queue");

  a_empty_avg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[51]) |-> (out_tdata[100:52] == '0))
    else $error("averages nonzero while no samples held");

  a_accepted_has_samples: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[1:0] == FS_ACCEPTED)) |-> out_tdata[51])
    else $error("accepted frame reported with empty averages");

endmodule

// ----- sv/sada_front.sv -----
// byte front end: header check, field capture and frame judgement
`timescale 1ns / 1ps
module sada_front import sada_pkg::*; #(
  parameter int MIN_FRAME_BYTES = DEF_MIN_FRAME_BYTES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [MAC_W-1:0]      cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  in_tuser,
  input  logic                  in_tlast,
  input  sada_qstat_t           q_stat,
  output logic                  q_push,
  output sada_evt_t             q_wdata
);

  localparam logic [POS_W-1:0] MIN_LAST_POS = POS_W'(MIN_FRAME_BYTES - 1);

  logic [MAC_W-1:0]    allowed_mac_r;
  logic [POS_W-1:0]    pos_r;
  logic                hdr_ok_r;
  logic [FIELDS_W-1:0] fields_r;

  logic                accept;
  logic [7:0]          data_byte;
  logic [MAC_W-1:0]    sender_mac;
  logic                in_hdr;
  logic                in_fld;
  logic                hdr_ok_now;
  logic [FIELDS_W-1:0] fields_now;
  frame_status_t       status;

  assign in_tready  = !q_stat.full;
  assign accept     = in_tvalid && in_tready;
  assign data_byte  = in_tdata[7:0];
  assign sender_mac = in_tdata[55:8];

  assign in_hdr     = pos_r < HDR_BYTES;
  assign in_fld     = (pos_r >= HDR_BYTES) && (pos_r < FIELD_END);
  assign hdr_ok_now = hdr_ok_r && (!in_hdr || (data_byte == header_byte(pos_r[1:0])));
  assign fields_now = in_fld ? {fields_r[FIELDS_W-9:0], data_byte} : fields_r;

  // checks in priority order: length, header, sender
  always_comb begin
    if (pos_r < MIN_LAST_POS) begin
      status = FS_TOO_SHORT;
    end else if (!hdr_ok_now) begin
      status = FS_BAD_HEADER;
    end else if (sender_mac != allowed_mac_r) begin
      status = FS_BAD_ADDR;
    end else begin
      status = FS_ACCEPTED;
    end
  end

  assign q_push           = accept && (in_tuser || in_tlast);
  assign q_wdata.is_clear = in_tuser;
  assign q_wdata.status   = status;
  assign q_wdata.fields   = fields_now;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      allowed_mac_r <= '0;
      pos_r         <= '0;
      hdr_ok_r      <= 1'b1;
      fields_r      <= '0;
    end else begin
      if (cfg_we) begin
        allowed_mac_r <= cfg_wdata;
      end
      // a clear word leaves the frame in progress alone
      if (accept && !in_tuser) begin
        if (in_tlast) begin
          pos_r    <= '0;
          hdr_ok_r <= 1'b1;
          fields_r <= '0;
        end else begin
          pos_r    <= (pos_r == POS_MAX) ? pos_r : pos_r + 1'b1;
          hdr_ok_r <= hdr_ok_now;
          fields_r <= fields_now;
        end
      end
    end
  end

endmodule

// ----- sv/sada_queue.sv -----
// short event queue between front end and back end
`timescale 1ns / 1ps
module sada_queue import sada_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  sada_evt_t   wdata,
  input  logic        pop,
  output sada_evt_t   rdata,
  output sada_qstat_t stat
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  sada_evt_t        entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] fill_r;

  assign stat.full  = fill_r == CNT_W'(QUEUE_DEPTH);
  assign stat.empty = fill_r == '0;
  assign rdata      = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill_r <= fill_r + 1'b1;
        2'b01:   fill_r <= fill_r - 1'b1;
        default: fill_r <= fill_r;
      endcase
    end
  end

endmodule

// ----- sv/sada_back.sv -----
// back end: latest values, running sums and serial averaging
`timescale 1ns / 1ps
module sada_back import sada_pkg::*; #(
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sada_evt_t              q_head,
  input  sada_qstat_t            q_stat,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int TSW   = 16 + COUNT_BITS;
  localparam int HSW   = 16 + COUNT_BITS;
  localparam int PSW   = 17 + COUNT_BITS;
  localparam int DW    = PSW;
  localparam int CNT_W = $clog2(DW + 1);
  localparam logic [COUNT_BITS-1:0] COUNT_FULL = '1;

  back_state_t state_r, state_nxt;
  sada_evt_t   ev_r;

  logic signed [15:0]     lat_temp_r;
  logic [15:0]            lat_hum_r;
  logic [16:0]            lat_press_r;
  logic signed [TSW-1:0]  tsum_r;
  logic [HSW-1:0]         hsum_r;
  logic [PSW-1:0]         psum_r;
  logic [COUNT_BITS-1:0]  count_r;

  logic [DW-1:0]          quo_r [3];
  logic [COUNT_BITS-1:0]  rem_r [3];
  logic [DW-1:0]          quo_step [3];
  logic [COUNT_BITS-1:0]  rem_step [3];
  logic [COUNT_BITS:0]    shl [3];
  logic                   ge [3];
  logic                   tneg_r;
  logic [CNT_W-1:0]       div_cnt_r;

  logic                   out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  logic do_pop, do_accum, do_load, do_step, do_out;

  logic signed [15:0] new_temp;
  logic [16:0]        new_press;
  logic [TSW-1:0]     tsum_u;
  logic [TSW-1:0]     tmag;
  logic               avg_ok;
  logic [16:0]        tq17;
  logic [16:0]        tq_signed;
  logic [15:0]        avg_t;
  logic [15:0]        avg_h;
  logic [16:0]        avg_p;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty && !q_head.is_clear) begin
          state_nxt = BK_ACCUM;
        end
      end
      BK_ACCUM: state_nxt = BK_LOAD;
      BK_LOAD:  state_nxt = BK_DIV;
      BK_DIV: begin
        if (div_cnt_r == CNT_W'(1)) begin
          state_nxt = BK_OUT;
        end
      end
      BK_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    do_pop   = 1'b0;
    do_accum = 1'b0;
    do_load  = 1'b0;
    do_step  = 1'b0;
    do_out   = 1'b0;
    unique case (state_r)
      BK_IDLE:  do_pop   = !q_stat.empty;
      BK_ACCUM: do_accum = 1'b1;
      BK_LOAD:  do_load  = 1'b1;
      BK_DIV:   do_step  = 1'b1;
      BK_OUT:   do_out   = !out_tvalid_r || out_tready;
      default:  do_pop   = 1'b0;
    endcase
  end

  assign q_pop = do_pop;

  assign new_temp  = ev_r.fields[47:32];
  assign new_press = 17'(ev_r.fields[15:0]) + PRESSURE_OFFSET;

  // magnitude of the temperature sum, sign restored after the divide
  assign tsum_u = tsum_r;
  assign tmag   = tsum_u[TSW-1] ? (~tsum_u + 1'b1) : tsum_u;

  // one restoring division step per lane
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      shl[i]      = {rem_r[i], quo_r[i][DW-1]};
      ge[i]       = shl[i] >= {1'b0, count_r};
      rem_step[i] = ge[i] ? COUNT_BITS'(shl[i] - {1'b0, count_r})
                          : shl[i][COUNT_BITS-1:0];
      quo_step[i] = {quo_r[i][DW-2:0], ge[i]};
    end
  end

  assign avg_ok    = count_r != '0;
  assign tq17      = quo_r[0][16:0];
  assign tq_signed = tneg_r ? (~tq17 + 1'b1) : tq17;
  assign avg_t     = avg_ok ? tq_signed[15:0] : '0;
  assign avg_h     = avg_ok ? quo_r[1][15:0] : '0;
  assign avg_p     = avg_ok ? quo_r[2][16:0] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_IDLE;
      lat_temp_r   <= '0;
      lat_hum_r    <= '0;
      lat_press_r  <= '0;
      tsum_r       <= '0;
      hsum_r       <= '0;
      psum_r       <= '0;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (do_pop && q_head.is_clear) begin
        tsum_r  <= '0;
        hsum_r  <= '0;
        psum_r  <= '0;
        count_r <= '0;
      end
      if (do_accum && (ev_r.status == FS_ACCEPTED)) begin
        lat_temp_r  <= new_temp;
        lat_hum_r   <= ev_r.fields[31:16];
        lat_press_r <= new_press;
        // a full count freezes the averages
        if (count_r != COUNT_FULL) begin
          tsum_r  <= tsum_r + TSW'(new_temp);
          hsum_r  <= hsum_r + HSW'(ev_r.fields[31:16]);
          psum_r  <= psum_r + PSW'(new_press);
          count_r <= count_r + 1'b1;
        end
      end
      if (do_out) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop) begin
      ev_r <= q_head;
    end
    if (do_load) begin
      tneg_r    <= tsum_u[TSW-1];
      quo_r[0]  <= DW'(tmag);
      quo_r[1]  <= DW'(hsum_r);
      quo_r[2]  <= psum_r;
      rem_r[0]  <= '0;
      rem_r[1]  <= '0;
      rem_r[2]  <= '0;
      div_cnt_r <= CNT_W'(DW);
    end
    if (do_step) begin
      for (int i = 0; i < 3; i++) begin
        quo_r[i] <= quo_step[i];
        rem_r[i] <= rem_step[i];
      end
      div_cnt_r <= div_cnt_r - 1'b1;
    end
    if (do_out) begin
      out_tdata_r <= {3'b000, 16'(count_r), avg_p, avg_h, avg_t, avg_ok,
                      lat_press_r, lat_hum_r, lat_temp_r, ev_r.status};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule
